>>> hdl/gprs_pkg.sv
// Shared types and constants for the grid path rubberband smoother.
package gprs_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int COORD_W       = 6;
  localparam int LAYER_W       = 8;
  localparam int QDEPTH        = 4;
  localparam int QW            = $clog2(QDEPTH);

  localparam logic [LAYER_W-1:0] WALL_LAYER_RST = 8'd1;

  // Input word action codes
  localparam logic ACT_POINT   = 1'b0;
  localparam logic ACT_TERRAIN = 1'b1;

  // Path progress: nothing held, anchor held, anchor and pending point held
  typedef enum logic [1:0] {
    PS_NONE,
    PS_ANCHOR,
    PS_PENDING
  } gprs_seen_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } gprs_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               eop;
  } gprs_res_t;

endpackage

>>> hdl/gprs_ram.sv
// Generic single write port, single read port RAM with registered read.
module gprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/grid_path_rubberband_smoother.sv
// Grid path rubberband smoother: terrain map in RAM, bounding-box wall scan one cell a cycle.
// The first point, and a last point that follows only the anchor, push a word on acceptance;
// a second point that is not last is held pending. A middle point is decided by scanning
// the box anchor..next point via the registered RAM read, stopping early on the first wall.
// Throughput: terrain writes and unscanned points one per cycle unless stalled; scans stall input.
// Reset: synchronous, active low; a clearing pass then writes zero to every terrain cell.
module grid_path_rubberband_smoother
  import gprs_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [COORD_W-1:0] in_cell_x,
  input  logic [COORD_W-1:0] in_cell_y,
  input  logic [LAYER_W-1:0] in_layer_id,
  input  logic               in_last_point,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_point_x,
  output logic [COORD_W-1:0] out_point_y,
  output logic               out_end_of_path,
  // wall layer register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LAYER_W-1:0] cfg_wall_layer
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  // State and path registers
  gprs_state_t        state_r, state_nxt;
  gprs_seen_t         seen_r, seen_nxt;
  logic [LAYER_W-1:0] wall_layer_r;
  logic [COORD_W-1:0] anchor_x_r, anchor_x_nxt, anchor_y_r, anchor_y_nxt;
  logic [COORD_W-1:0] pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic               cur_last_r, cur_last_nxt;
  logic [COORD_W-1:0] box_x0_r, box_x0_nxt, box_x1_r, box_x1_nxt;
  logic [COORD_W-1:0] box_y0_r, box_y0_nxt, box_y1_r, box_y1_nxt;
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic               rd_v_r, rd_v_nxt, rd_in_r, rd_in_nxt;
  logic [AW-1:0]      clr_addr_r;

  // Result queue
  gprs_res_t          q_r [QDEPTH];
  logic [QW-1:0]      q_wr_r, q_rd_r;
  logic [QW:0]        q_cnt_r;
  logic [1:0]         push_n;
  gprs_res_t          res0, res1;
  logic               pop;

  // RAM port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LAYER_W-1:0] ram_wdata, ram_rdata;

  logic               acc, hit, wall, in_grid_wr;

  gprs_ram #(
    .WIDTH (LAYER_W),
    .DEPTH (DEPTH)
  ) u_terrain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  // Handshakes
  assign in_stall  = !((state_r == ST_IDLE) && (q_cnt_r <= (QW+1)'(QDEPTH - 2)));
  assign acc       = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  assign out_point_x     = q_r[q_rd_r].x;
  assign out_point_y     = q_r[q_rd_r].y;
  assign out_end_of_path = q_r[q_rd_r].eop;

  // Wall seen on the read issued last cycle
  assign hit = rd_v_r && rd_in_r && (ram_rdata == wall_layer_r);

  assign in_grid_wr = (32'(in_cell_x) < GRID_SIZE) && (32'(in_cell_y) < GRID_SIZE);

  // Next state, RAM access and result pushes
  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cur_last_nxt = cur_last_r;
    box_x0_nxt   = box_x0_r;
    box_x1_nxt   = box_x1_r;
    box_y0_nxt   = box_y0_r;
    box_y1_nxt   = box_y1_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    rd_v_nxt     = 1'b0;
    rd_in_nxt    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(32'(in_cell_x) * GRID_SIZE + 32'(in_cell_y));
    ram_wdata    = in_layer_id;
    ram_raddr    = AW'(32'(sx_r) * GRID_SIZE + 32'(sy_r));
    push_n       = 2'd0;
    res0         = '{x: in_cell_x, y: in_cell_y, eop: in_last_point};
    res1         = res0;
    wall         = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (acc && (in_action == ACT_TERRAIN)) begin
          ram_we = in_grid_wr;
        end else if (acc) begin
          unique case (seen_r)
            PS_NONE: begin
              push_n       = 2'd1;
              anchor_x_nxt = in_cell_x;
              anchor_y_nxt = in_cell_y;
              seen_nxt     = in_last_point ? PS_NONE : PS_ANCHOR;
            end
            PS_ANCHOR: begin
              if (in_last_point) begin
                push_n   = 2'd1;
                seen_nxt = PS_NONE;
              end else begin
                pend_x_nxt = in_cell_x;
                pend_y_nxt = in_cell_y;
                seen_nxt   = PS_PENDING;
              end
            end
            default: begin
              // set up the box from anchor to the new point
              cur_x_nxt    = in_cell_x;
              cur_y_nxt    = in_cell_y;
              cur_last_nxt = in_last_point;
              box_x0_nxt   = (anchor_x_r < in_cell_x) ? anchor_x_r : in_cell_x;
              box_x1_nxt   = (anchor_x_r < in_cell_x) ? in_cell_x : anchor_x_r;
              box_y0_nxt   = (anchor_y_r < in_cell_y) ? anchor_y_r : in_cell_y;
              box_y1_nxt   = (anchor_y_r < in_cell_y) ? in_cell_y : anchor_y_r;
              sx_nxt       = box_x0_nxt;
              sy_nxt       = box_y0_nxt;
              state_nxt    = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!hit) begin
          // issue the read of one box cell
          rd_v_nxt  = 1'b1;
          rd_in_nxt = (32'(sx_r) < GRID_SIZE) && (32'(sy_r) < GRID_SIZE);
          if ((sx_r == box_x1_r) && (sy_r == box_y1_r)) begin
            state_nxt = ST_DRAIN;
          end else if (sy_r == box_y1_r) begin
            sy_nxt = box_y0_r;
            sx_nxt = sx_r + 1'b1;
          end
          else begin
            sy_nxt = sy_r + 1'b1;
          end
        end
      end

      ST_DRAIN: begin
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Finish the scan: wall found early, or last read checked
    if (((state_r == ST_SCAN) && hit) || (state_r == ST_DRAIN)) begin
      wall      = hit;
      state_nxt = ST_IDLE;
      res0      = '{x: cur_x_r, y: cur_y_r, eop: 1'b1};
      if (wall) begin
        res0         = '{x: pend_x_r, y: pend_y_r, eop: 1'b0};
        res1         = '{x: cur_x_r, y: cur_y_r, eop: 1'b1};
        anchor_x_nxt = pend_x_r;
        anchor_y_nxt = pend_y_r;
        push_n       = 2'd1;
      end
      if (cur_last_r) begin
        push_n   = push_n + 2'd1;
        seen_nxt = PS_NONE;
      end else begin
        pend_x_nxt = cur_x_r;
        pend_y_nxt = cur_y_r;
        seen_nxt   = PS_PENDING;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      seen_r       <= PS_NONE;
      wall_layer_r <= WALL_LAYER_RST;
      anchor_x_r   <= '0;
      anchor_y_r   <= '0;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
      rd_v_r       <= 1'b0;
      clr_addr_r   <= '0;
      q_wr_r       <= '0;
      q_rd_r       <= '0;
      q_cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      anchor_x_r <= anchor_x_nxt;
      anchor_y_r <= anchor_y_nxt;
      pend_x_r   <= pend_x_nxt;
      pend_y_r   <= pend_y_nxt;
      rd_v_r     <= rd_v_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        wall_layer_r <= cfg_wall_layer;
      end
      q_wr_r  <= q_wr_r + QW'(push_n);
      q_rd_r  <= q_rd_r + QW'(pop);
      q_cnt_r <= q_cnt_r + (QW+1)'(push_n) - (QW+1)'(pop);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    cur_last_r <= cur_last_nxt;
    box_x0_r   <= box_x0_nxt;
    box_x1_r   <= box_x1_nxt;
    box_y0_r   <= box_y0_nxt;
    box_y1_r   <= box_y1_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    rd_in_r    <= rd_in_nxt;
    if (push_n != 2'd0) begin
      q_r[q_wr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[q_wr_r + QW'(1)] <= res1;
    end
  end

endmodule
